@@ rtl/tga_pkg.sv @@
// ----------------------------------------------------------------------------
// tga_pkg
// Shared widths, register map, configuration and result types, and the
// command/status bundles between the decoder controller and its datapath.
// ----------------------------------------------------------------------------
package tga_pkg;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int COORD_W    = 16;
   localparam int BPP_W      = 3;
   localparam int COUNT_W    = 8;
   localparam int LANE_W     = 2;
   localparam int PIX_W      = 4 * BYTE_W;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int SUM_W      = COORD_W + 1;
   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // Pixel format constants
   localparam logic [BPP_W-1:0]  BPP_BGR       = 3'd3;
   localparam logic [LANE_W-1:0] LAST_LANE_BGR  = 2'd2;
   localparam logic [LANE_W-1:0] LAST_LANE_BGRA = 2'd3;
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE  = 8'hff;
   localparam int                RUN_FLAG_BIT  = 7;

   // Register reset values
   localparam logic [COORD_W-1:0] RST_IMAGE_WIDTH     = 16'd1;
   localparam logic [COORD_W-1:0] RST_IMAGE_HEIGHT    = 16'd1;
   localparam logic [BPP_W-1:0]   RST_BYTES_PER_PIXEL = 3'd4;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH     = 3'd0,
      REG_IMAGE_HEIGHT    = 3'd1,
      REG_BYTES_PER_PIXEL = 3'd2,
      REG_COMPRESSED      = 3'd3,
      REG_TOP_LEFT_ORIGIN = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] image_width;
      logic [COORD_W-1:0] image_height;
      logic [BPP_W-1:0]   bytes_per_pixel;
      logic               compressed;
      logic               top_left_origin;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] dest_col;
      logic [COORD_W-1:0] dest_row;
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  alpha;
      logic [COUNT_W-1:0] repeat_count;
      logic               image_done;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_PROC,
      ST_MULT,
      ST_CLIP,
      ST_ADV,
      ST_ADV_DIV,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_byte;
      logic norm_start;
      logic norm_commit;
      logic set_finished;
      logic proc;
      logic mult;
      logic clip;
      logic adv_start;
      logic adv_commit;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic finished;
      logic col_ge_w;
      logic row_ge_h;
      logic norm_over;
      logic hdr_phase;
      logic pixel_last;
      logic run_multi;
      logic sum_lt_w;
      logic div_busy;
      logic div_done;
   } stat_type;

endpackage

@@ rtl/tga_req_if.sv @@
// ----------------------------------------------------------------------------
// tga_req_if
// Byte stream channel: one image-data byte per transaction.
// ----------------------------------------------------------------------------
interface tga_req_if import tga_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/tga_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tga_rsp_if
// Result channel: one decoded pixel or run per transaction.
// ----------------------------------------------------------------------------
interface tga_rsp_if import tga_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] dest_col;
   logic [COORD_W-1:0] dest_row;
   logic [BYTE_W-1:0]  red;
   logic [BYTE_W-1:0]  green;
   logic [BYTE_W-1:0]  blue;
   logic [BYTE_W-1:0]  alpha;
   logic [COUNT_W-1:0] repeat_count;
   logic               image_done;

   modport source (
      output valid, output dest_col, output dest_row, output red, output green,
      output blue, output alpha, output repeat_count, output image_done,
      input ready
   );
   modport sink (
      input valid, input dest_col, input dest_row, input red, input green,
      input blue, input alpha, input repeat_count, input image_done,
      output ready
   );
endinterface

@@ rtl/tga_divider.sv @@
// ----------------------------------------------------------------------------
// tga_divider
// Restoring divider, one quotient bit per cycle. Splits a linear offset
// within the image into whole rows and the column left over.
// ----------------------------------------------------------------------------
module tga_divider import tga_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [COORD_W-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic [SUM_W-1:0]   quotient,
   output logic [COORD_W-1:0] remainder
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [COORD_W-1:0]   dvs_ff, dvs_in;
   logic [SUM_W-1:0]     trial;
   logic [SUM_W-1:0]     diff;
   logic                 fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], fits};
         rem_in = fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/tga_datapath.sv @@
// ----------------------------------------------------------------------------
// tga_datapath
// Packet state, pixel assembly, image position, run clipping and the result
// register. Acts on commands from the controller and reports status back.
// ----------------------------------------------------------------------------
module tga_datapath import tga_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           cmd,
   input  logic [BYTE_W-1:0] req_byte,
   output stat_type          stat,
   output rsp_data_type      rsp_data
);

   logic                 expect_header_ff, expect_header_in;
   logic                 packet_is_run_ff, packet_is_run_in;
   logic [COUNT_W-1:0]   packet_left_ff, packet_left_in;
   logic [LANE_W-1:0]    byte_index_ff, byte_index_in;
   logic [PIX_W-1:0]     pixel_bytes_ff, pixel_bytes_in;
   logic [COORD_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic                 finished_ff, finished_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [COORD_W-1:0]   new_col_ff, new_col_in;
   logic [SUM_W-1:0]     new_row_ff, new_row_in;
   rsp_data_type         out_ff, out_in;

   logic [COORD_W-1:0]   w_eff;
   logic [COORD_W-1:0]   h_eff;
   logic                 bpp_is_bgr;
   logic [LANE_W-1:0]    last_lane;
   logic [SUM_W-1:0]     row_plus;
   logic [SUM_W-1:0]     adv_sum;
   logic [COUNT_W-1:0]   left_dec;
   logic [COORD_W-1:0]   rows_left;
   logic [PROD_W-1:0]    remain;
   logic                 new_done;
   logic                 div_start;
   logic [SUM_W-1:0]     div_dividend;
   logic                 div_busy;
   logic                 div_done;
   logic [SUM_W-1:0]     div_quo;
   logic [COORD_W-1:0]   div_rem;

   // Geometry and format as used: zero width or height counts as one
   assign w_eff      = (cfg.image_width == '0) ? COORD_W'(1) : cfg.image_width;
   assign h_eff      = (cfg.image_height == '0) ? COORD_W'(1) : cfg.image_height;
   assign bpp_is_bgr = (cfg.bytes_per_pixel == BPP_BGR);
   assign last_lane  = bpp_is_bgr ? LAST_LANE_BGR : LAST_LANE_BGRA;

   assign row_plus  = {1'b0, row_ff} + div_quo;
   assign adv_sum   = {1'b0, col_ff} + SUM_W'(count_ff);
   assign rows_left = h_eff - row_ff;
   assign remain    = prod_ff - PROD_W'(col_ff);
   assign new_done  = (new_row_ff >= {1'b0, h_eff});
   assign left_dec  = (packet_left_ff == '0) ? '0 : packet_left_ff - COUNT_W'(1);

   // Status towards the controller
   always_comb begin
      stat.finished   = finished_ff;
      stat.col_ge_w   = (col_ff >= w_eff);
      stat.row_ge_h   = (row_ff >= h_eff);
      stat.norm_over  = (row_plus >= {1'b0, h_eff});
      stat.hdr_phase  = cfg.compressed & expect_header_ff;
      stat.pixel_last = (byte_index_ff >= last_lane);
      stat.run_multi  = cfg.compressed & packet_is_run_ff & (packet_left_ff > COUNT_W'(1));
      stat.sum_lt_w   = (adv_sum < {1'b0, w_eff});
      stat.div_busy   = div_busy;
      stat.div_done   = div_done;
   end

   // Shared divider: re-derive the position, or advance it past a pixel or run
   assign div_start    = cmd.norm_start | (cmd.adv_start & ~stat.sum_lt_w);
   assign div_dividend = cmd.norm_start ? {1'b0, col_ff} : adv_sum;

   tga_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (w_eff),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Next values
   always_comb begin
      expect_header_in = expect_header_ff;
      packet_is_run_in = packet_is_run_ff;
      packet_left_in   = packet_left_ff;
      byte_index_in    = byte_index_ff;
      pixel_bytes_in   = pixel_bytes_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      finished_in      = finished_ff;
      byte_in          = byte_ff;
      count_in         = count_ff;
      prod_in          = prod_ff;
      new_col_in       = new_col_ff;
      new_row_in       = new_row_ff;
      out_in           = out_ff;

      if (cmd.load_byte) begin
         byte_in = req_byte;
      end

      if (cmd.set_finished) begin
         finished_in = 1'b1;
      end

      // Commit the re-derived position, or finish if it lies past the end
      if (cmd.norm_commit) begin
         if (stat.norm_over) begin
            finished_in = 1'b1;
         end else begin
            row_in = row_plus[COORD_W-1:0];
            col_in = div_rem;
         end
      end

      // Take a packet header, or place a pixel byte in its lane
      if (cmd.proc) begin
         if (stat.hdr_phase) begin
            packet_is_run_in = byte_ff[RUN_FLAG_BIT];
            packet_left_in   = {1'b0, byte_ff[RUN_FLAG_BIT-1:0]} + COUNT_W'(1);
            expect_header_in = 1'b0;
            byte_index_in    = '0;
         end else begin
            pixel_bytes_in[{byte_index_ff, 3'b000} +: BYTE_W] = byte_ff;
            if (!stat.pixel_last) begin
               byte_index_in = byte_index_ff + LANE_W'(1);
            end else begin
               byte_index_in = '0;
               count_in      = COUNT_W'(1);
               if (cfg.compressed) begin
                  if (packet_is_run_ff) begin
                     count_in         = (packet_left_ff == '0) ? COUNT_W'(1) : packet_left_ff;
                     packet_left_in   = '0;
                     expect_header_in = 1'b1;
                  end else begin
                     packet_left_in = left_dec;
                     if (left_dec == '0) begin
                        expect_header_in = 1'b1;
                     end
                  end
               end
            end
         end
      end

      // Pixels from here to the end of the image, in two steps
      if (cmd.mult) begin
         prod_in = PROD_W'(rows_left) * PROD_W'(w_eff);
      end
      if (cmd.clip) begin
         if (PROD_W'(count_ff) > remain) begin
            count_in = remain[COUNT_W-1:0];
         end
      end

      // Advance the position past this result
      if (cmd.adv_start && stat.sum_lt_w) begin
         new_col_in = adv_sum[COORD_W-1:0];
         new_row_in = {1'b0, row_ff};
      end
      if (cmd.adv_commit) begin
         new_col_in = div_rem;
         new_row_in = row_plus;
      end

      // Load the result register and move to the next position
      if (cmd.emit) begin
         out_in.dest_col     = col_ff;
         out_in.dest_row     = cfg.top_left_origin ? row_ff
                                                   : (h_eff - COORD_W'(1) - row_ff);
         out_in.red          = pixel_bytes_ff[2*BYTE_W +: BYTE_W];
         out_in.green        = pixel_bytes_ff[BYTE_W +: BYTE_W];
         out_in.blue         = pixel_bytes_ff[0 +: BYTE_W];
         out_in.alpha        = bpp_is_bgr ? ALPHA_OPAQUE : pixel_bytes_ff[3*BYTE_W +: BYTE_W];
         out_in.repeat_count = count_ff;
         out_in.image_done   = new_done;
         col_in              = new_col_ff;
         row_in              = new_row_ff[COORD_W-1:0];
         if (new_done) begin
            finished_in = 1'b1;
         end
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         packet_is_run_ff <= 1'b0;
         packet_left_ff   <= '0;
         byte_index_ff    <= '0;
         pixel_bytes_ff   <= '0;
         col_ff           <= '0;
         row_ff           <= '0;
         finished_ff      <= 1'b0;
      end else begin
         expect_header_ff <= expect_header_in;
         packet_is_run_ff <= packet_is_run_in;
         packet_left_ff   <= packet_left_in;
         byte_index_ff    <= byte_index_in;
         pixel_bytes_ff   <= pixel_bytes_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         finished_ff      <= finished_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      count_ff   <= count_in;
      prod_ff    <= prod_in;
      new_col_ff <= new_col_in;
      new_row_ff <= new_row_in;
      out_ff     <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

@@ rtl/tga_ctrl.sv @@
// ----------------------------------------------------------------------------
// tga_ctrl
// Sequencer for the decoder: accepts bytes, steps the datapath through
// header, pixel, clip, position re-derive and position-advance phases, and owns the result valid.
// ----------------------------------------------------------------------------
module tga_ctrl import tga_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_byte = 1'b1;
               if (stat.finished) begin
                  state_in = ST_IDLE;
               end else if (stat.col_ge_w) begin
                  cmd.norm_start = 1'b1;
                  state_in       = ST_NORM;
               end else if (stat.row_ge_h) begin
                  cmd.set_finished = 1'b1;
               end else begin
                  state_in = ST_PROC;
               end
            end
         end
         ST_NORM: begin
            if (stat.div_done) begin
               cmd.norm_commit = 1'b1;
               state_in        = stat.norm_over ? ST_IDLE : ST_PROC;
            end
         end
         ST_PROC: begin
            cmd.proc = 1'b1;
            if (stat.hdr_phase || !stat.pixel_last) begin
               state_in = ST_IDLE;
            end else if (stat.run_multi) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            cmd.adv_start = 1'b1;
            state_in      = stat.sum_lt_w ? ST_EMIT : ST_ADV_DIV;
         end
         ST_ADV_DIV: begin
            if (stat.div_done) begin
               cmd.adv_commit = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // The divider is running or reporting whenever the sequencer waits on it
   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM || state_ff == ST_ADV_DIV) |-> (stat.div_busy || stat.div_done))
      else $error("sequencer waits on an idle divider");

   // A finished image never leaves the sequencer mid-item
   a_no_work_when_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !stat.finished)
      else $error("item in progress after image completion");

   // A new result appears only out of the emit phase
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result valid raised outside emit phase");

endmodule

@@ rtl/tga_pixel_stream_decoder.sv @@
// Flow: an accepted byte is loaded in IDLE and handled in PROC; a pixel-completing byte then
//   passes MULT and CLIP for a multi-pixel run, ADV, ADV_DIV (one divider pass) when the run
//   or pixel crosses a row end, and EMIT, which holds while the previous result still waits.
// The next byte is accepted only back in IDLE; a column past a narrowed width first takes a
//   divider pass in NORM.
// Reset: synchronous; state and register-port flops return to their reset values, the decoder to image start.
// ----------------------------------------------------------------------------
// tga_pixel_stream_decoder
// Run-length and raw TGA image-data decoder for 24- and 32-bit pixels, with
// an APB-style register port for geometry and format.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder import tga_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tga_req_if.sink               req_chan,
   tga_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_idx;
   logic          csr_write;
   cmd_type       cmd;
   stat_type      stat;
   rsp_data_type  rsp_data;

   // Register port decode
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_IMAGE_WIDTH:     cfg_in.image_width     = csr_pwdata[COORD_W-1:0];
            REG_IMAGE_HEIGHT:    cfg_in.image_height    = csr_pwdata[COORD_W-1:0];
            REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_pwdata[BPP_W-1:0];
            REG_COMPRESSED:      cfg_in.compressed      = csr_pwdata[0];
            REG_TOP_LEFT_ORIGIN: cfg_in.top_left_origin = csr_pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= RST_IMAGE_WIDTH;
         cfg_ff.image_height    <= RST_IMAGE_HEIGHT;
         cfg_ff.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
         cfg_ff.compressed      <= 1'b0;
         cfg_ff.top_left_origin <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      case (csr_idx)
         REG_IMAGE_WIDTH:     csr_prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:    csr_prdata = CSR_DATA_W'(cfg_ff.image_height);
         REG_BYTES_PER_PIXEL: csr_prdata = CSR_DATA_W'(cfg_ff.bytes_per_pixel);
         REG_COMPRESSED:      csr_prdata = CSR_DATA_W'(cfg_ff.compressed);
         REG_TOP_LEFT_ORIGIN: csr_prdata = CSR_DATA_W'(cfg_ff.top_left_origin);
         default:             csr_prdata = '0;
      endcase
   end

   tga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tga_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .req_byte (req_chan.data_byte),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // Result payload
   assign rsp_chan.dest_col     = rsp_data.dest_col;
   assign rsp_chan.dest_row     = rsp_data.dest_row;
   assign rsp_chan.red          = rsp_data.red;
   assign rsp_chan.green        = rsp_data.green;
   assign rsp_chan.blue         = rsp_data.blue;
   assign rsp_chan.alpha        = rsp_data.alpha;
   assign rsp_chan.repeat_count = rsp_data.repeat_count;
   assign rsp_chan.image_done   = rsp_data.image_done;

endmodule

@@ sim/tga_decoder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_decoder_checker
// Monitors the byte, result and register ports of the TGA pixel stream
// decoder. Tracks the register settings and decoder state, predicts each
// decoded pixel or run, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tga_decoder_checker import tga_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tga_req_if                    req_mon,
   tga_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    pending,
   output int                    results_seen,
   output logic [COORD_W-1:0]    cur_row,
   output logic [COORD_W-1:0]    cur_col
);

   // Shadow registers and decoder state
   cfg_type            cfg;
   logic               hdr_due;
   logic               run_pkt;
   logic               done;
   logic [COUNT_W-1:0] pkt_left;
   logic [LANE_W-1:0]  lane;
   logic [PIX_W-1:0]   pix;
   logic [COORD_W-1:0] src_row;
   logic [COORD_W-1:0] src_col;
   rsp_data_type       pixel_q[$];

   // Consume one image byte; return 1 with the decoded pixel or run when one is due
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output rsp_data_type px);
      longint unsigned wd, ht, total, pos, cnt;
      int unsigned     last;
      px    = '0;
      wd    = (cfg.image_width == 0) ? 1 : cfg.image_width;
      ht    = (cfg.image_height == 0) ? 1 : cfg.image_height;
      total = wd * ht;
      last  = (cfg.bytes_per_pixel == BPP_BGR) ? LAST_LANE_BGR : LAST_LANE_BGRA;
      if (done)
         return 1'b0;

      // Re-derive the position over the current width
      pos = src_row * wd + src_col;
      if (pos >= total) begin
         done = 1'b1;
         return 1'b0;
      end
      src_row = COORD_W'(pos / wd);
      src_col = COORD_W'(pos % wd);

      // Packet header: no result
      if (cfg.compressed && hdr_due) begin
         run_pkt  = b[RUN_FLAG_BIT];
         pkt_left = COUNT_W'(b[RUN_FLAG_BIT-1:0]) + 1'b1;
         hdr_due  = 1'b0;
         lane     = '0;
         return 1'b0;
      end

      // Collect the pixel bytes in B, G, R, A order
      pix[lane*BYTE_W +: BYTE_W] = b;
      if (lane < last) begin
         lane = lane + 1'b1;
         return 1'b0;
      end
      lane = '0;

      if (!cfg.compressed) begin
         cnt = 1;
      end else if (run_pkt) begin
         cnt      = (pkt_left != 0) ? pkt_left : 1;
         pkt_left = '0;
         hdr_due  = 1'b1;
      end else begin
         cnt = 1;
         if (pkt_left != 0)
            pkt_left = pkt_left - 1'b1;
         if (pkt_left == 0)
            hdr_due = 1'b1;
      end

      // Clip the run to the pixels left in the image
      if (cnt > total - pos)
         cnt = total - pos;

      px.dest_col     = src_col;
      px.dest_row     = cfg.top_left_origin ? src_row : COORD_W'(ht - 1 - src_row);
      px.red          = pix[3*BYTE_W-1:2*BYTE_W];
      px.green        = pix[2*BYTE_W-1:BYTE_W];
      px.blue         = pix[BYTE_W-1:0];
      px.alpha        = (last == LAST_LANE_BGR) ? ALPHA_OPAQUE : pix[PIX_W-1:3*BYTE_W];
      px.repeat_count = COUNT_W'(cnt);

      // Advance past the run
      pos = pos + cnt;
      if (pos >= total)
         done = 1'b1;
      px.image_done = done;
      src_row       = COORD_W'(pos / wd);
      src_col       = COORD_W'(pos % wd);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_data_type want, got;
      if (reset) begin
         cfg.image_width     = RST_IMAGE_WIDTH;
         cfg.image_height    = RST_IMAGE_HEIGHT;
         cfg.bytes_per_pixel = RST_BYTES_PER_PIXEL;
         cfg.compressed      = 1'b0;
         cfg.top_left_origin = 1'b0;
         hdr_due      = 1'b1;
         run_pkt      = 1'b0;
         done         = 1'b0;
         pkt_left     = '0;
         lane         = '0;
         pix          = '0;
         src_row      = '0;
         src_col      = '0;
         mismatches   = 0;
         results_seen = 0;
         pixel_q.delete();
      end else begin
         // Track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_IMAGE_WIDTH:     cfg.image_width     = csr_pwdata[COORD_W-1:0];
               REG_IMAGE_HEIGHT:    cfg.image_height    = csr_pwdata[COORD_W-1:0];
               REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel = csr_pwdata[BPP_W-1:0];
               REG_COMPRESSED:      cfg.compressed      = csr_pwdata[0];
               REG_TOP_LEFT_ORIGIN: cfg.top_left_origin = csr_pwdata[0];
               default: ;
            endcase
         end

         // Predict on every accepted byte
         if (req_mon.valid && req_mon.ready) begin
            if (decode_byte(req_mon.data_byte, want))
               pixel_q.push_back(want);
         end

         // Compare every accepted result with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.dest_col     = rsp_mon.dest_col;
            got.dest_row     = rsp_mon.dest_row;
            got.red          = rsp_mon.red;
            got.green        = rsp_mon.green;
            got.blue         = rsp_mon.blue;
            got.alpha        = rsp_mon.alpha;
            got.repeat_count = rsp_mon.repeat_count;
            got.image_done   = rsp_mon.image_done;
            results_seen++;
            if (pixel_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result %0d arrived with no pixel outstanding", $time,
                           results_seen);
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("%0t: result %0d mismatch", $time, results_seen);
                     $display("   expected col %0d row %0d rgba %h %h %h %h count %0d done %0b",
                              want.dest_col, want.dest_row, want.red, want.green, want.blue,
                              want.alpha, want.repeat_count, want.image_done);
                     $display("   actual   col %0d row %0d rgba %h %h %h %h count %0d done %0b",
                              got.dest_col, got.dest_row, got.red, got.green, got.blue,
                              got.alpha, got.repeat_count, got.image_done);
                  end
                  mismatches++;
               end
            end
         end
      end
      pending = pixel_q.size();
      cur_row = src_row;
      cur_col = src_col;
   end

endmodule

@@ sim/tb_tga_pixel_stream_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tga_pixel_stream_decoder
// Drives TGA image-data bytes and register settings into the decoder, with
// random gaps and stalls on both channels, and reports the verdict from the
// checker that predicts and compares every decoded pixel or run.
// ----------------------------------------------------------------------------
module tb_tga_pixel_stream_decoder;
   import tga_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_BYTES  = 1500;
   localparam int QUIET_FROM    = 1200;
   localparam int LONG_HOLD     = 200;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    mismatches;
   int                    pending;
   int                    results_seen;
   logic [COORD_W-1:0]    cur_row;
   logic [COORD_W-1:0]    cur_col;

   bit                    gaps_on;
   int                    hold_left;
   int                    bytes_sent;
   int                    settings;
   int                    quiet;

   tga_req_if req_chan ();
   tga_rsp_if rsp_chan ();

   tga_pixel_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tga_decoder_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen),
      .cur_row      (cur_row),
      .cur_col      (cur_col)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result receiver: random stall bursts, or a long hold when requested
   initial begin
      int burst;
      burst = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_chan.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(0, 2);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable)) begin
         quiet <= 0;
      end else if (quiet == STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Offer one byte, with an occasional gap first; returns at a falling edge
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_pixel(input int n_bytes);
      repeat (n_bytes) push_byte(BYTE_W'($urandom));
   endtask

   // Hold the stream until every predicted result is out, then let the block go quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic load_format(input logic [COORD_W-1:0] wd, input logic [COORD_W-1:0] ht,
                              input logic [BPP_W-1:0] bpp, input bit coded, input bit top_first);
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(wd));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(ht));
      write_reg(REG_BYTES_PER_PIXEL, CSR_DATA_W'(bpp));
      write_reg(REG_COMPRESSED, CSR_DATA_W'(coded));
      write_reg(REG_TOP_LEFT_ORIGIN, CSR_DATA_W'(top_first));
      settings++;
   endtask

   // Mostly well-formed packets with random content, some stray bytes
   task automatic random_stream(input int n_bytes, input bit coded, input int px_bytes);
      int start, n;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         if ($urandom_range(0, 9) == 0) begin
            push_byte(BYTE_W'($urandom));
         end else if (!coded) begin
            send_pixel(px_bytes);
         end else if ($urandom_range(0, 2) != 0) begin
            n = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 128);
            push_byte(8'h80 | BYTE_W'(n - 1));
            send_pixel(px_bytes);
         end else begin
            n = $urandom_range(0, 3) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            push_byte(BYTE_W'(n - 1));
            repeat (n) send_pixel(px_bytes);
         end
      end
   endtask

   initial begin
      logic [COORD_W-1:0] wd, ht;
      logic [BPP_W-1:0]   bpp;
      bit                 coded;
      int                 random_start, lin;

      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      gaps_on            = 1'b1;
      hold_left          = 0;
      bytes_sent         = 0;
      settings           = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full-width single row with zero height, raw 24-bit pixels, stop mid-pixel
      load_format(16'hffff, 16'h0000, BPP_BGR, 1'b0, 1'b0);
      repeat (3) push_byte(8'h00);
      repeat (3) push_byte(8'hff);
      push_byte(8'ha5);
      push_byte(8'h5a);
      settle();

      // Zero width folds the position onto rows; finish the pixel as 32-bit
      load_format(16'h0000, 16'hffff, 3'd4, 1'b0, 1'b0);
      push_byte(8'h3c);
      push_byte(8'hc3);
      send_pixel(4);
      settle();

      // Coded stream with an odd pixel size: longest run, then a one-pixel raw packet
      load_format(16'd5, 16'hffff, 3'd7, 1'b1, 1'b1);
      push_byte(8'hff);
      send_pixel(4);
      push_byte(8'h00);
      send_pixel(4);

      // Random settings phase by phase; the decoder state carries across them
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         settle();
         case ($urandom_range(0, 7))
            0:       wd = 16'hffff;
            1:       wd = COORD_W'($urandom_range(1, 65535));
            default: wd = COORD_W'($urandom_range(1, 40));
         endcase
         ht    = ($urandom_range(0, 3) == 0) ? 16'hffff : COORD_W'($urandom_range(50000, 65535));
         bpp   = ($urandom_range(0, 5) == 0) ? BPP_W'($urandom_range(0, 7))
                                             : ($urandom_range(0, 1) ? BPP_BGR : 3'd4);
         coded = ($urandom_range(0, 4) != 0);
         gaps_on = (bytes_sent - random_start < QUIET_FROM) && ($urandom_range(0, 3) != 0);
         load_format(wd, ht, bpp, coded, 1'($urandom_range(0, 1)));

         // Hold the receiver off while bytes keep coming
         if (settings == 5)
            hold_left = LONG_HOLD;
         random_stream($urandom_range(40, 120), coded, (bpp == BPP_BGR) ? 3 : 4);

         // Pause the stream mid-phase until the output has drained
         if (settings == 7) begin
            req_chan.valid <= 1'b0;
            while (pending != 0) @(negedge clock);
            random_stream($urandom_range(20, 60), coded, (bpp == BPP_BGR) ? 3 : 4);
         end
      end

      // Shrink the image to a few pixels past the current position, overrun it with runs
      settle();
      gaps_on = 1'b0;
      lin = cur_row * 8 + cur_col;
      load_format(16'd8, COORD_W'(lin / 8 + 2), BPP_BGR, 1'b1, 1'b0);
      repeat (12) begin
         push_byte(8'hff);
         send_pixel(3);
      end
      settle();

      $display("Summary: %0d bytes under %0d register settings, %0d results checked",
               bytes_sent, settings, results_seen);
      $display("Covered raw and coded packets, format and geometry changes mid-stream, ",
               "output back-pressure and a clipped final run");
      if (mismatches == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
